// ----- rtl/etmb_pkg.sv -----
package etmb_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int QW = 32;

    localparam logic signed [31:0] Q24_PI      = 32'sd52707179;
    localparam logic signed [31:0] Q24_HALF_PI = 32'sd26353589;
    localparam logic signed [31:0] Q24_GAIN    = 32'sd10188014;
    localparam logic signed [31:0] Q16_ONE     = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } out_item_t;

    // trig results for the three angles (Q24), with the item's position and scale
    typedef struct packed {
        logic signed [QW-1:0] cx;
        logic signed [QW-1:0] sx;
        logic signed [QW-1:0] cy;
        logic signed [QW-1:0] sy;
        logic signed [QW-1:0] cz;
        logic signed [QW-1:0] sz;
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
        logic signed [31:0]   scale_x;
        logic signed [31:0]   scale_y;
        logic signed [31:0]   scale_z;
    } trig_item_t;

    function automatic logic signed [QW-1:0] atan_step(input int i);
        logic signed [QW-1:0] r;
        case (i)
            0: r = 32'sd13176795;
            1: r = 32'sd7778716;
            2: r = 32'sd4110060;
            3: r = 32'sd2086331;
            4: r = 32'sd1047214;
            5: r = 32'sd524117;
            6: r = 32'sd262123;
            7: r = 32'sd131069;
            default: r = (i <= 24) ? (32'sd1 <<< (24 - i)) : 32'sd0;
        endcase
        return r;
    endfunction

    // round a Q24 product back down by 24 bits
    function automatic logic signed [QW-1:0] rnd24(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd8388608) >>> 24;
        return t[QW-1:0];
    endfunction

    function automatic logic signed [31:0] sat_rnd24(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd8388608) >>> 24;
        if (t > 64'sd2147483647) return 32'sh7fffffff;
        if (t < -64'sd2147483648) return 32'sh80000000;
        return t[31:0];
    endfunction

endpackage

// ----- rtl/euler_trs_matrix_builder.sv -----
// An accepted item passes TRIG_ITERATIONS+1 CORDIC stages, the queue write,
// 2 product stages and the output register before its row 0 is out.
// Rows 1..3 follow on consecutive cycles when the output is not stalled.
// All rows share one output port; a new item starts once the last row leaves.
// Reset: asynchronous active low; clears all valid flags and the queue.
module euler_trs_matrix_builder
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  etmb_pkg::in_item_t     in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output etmb_pkg::out_item_t    out_item
);
    logic                  fq_valid, fq_stall, qb_valid, qb_take;
    etmb_pkg::trig_item_t  fq_item, qb_item;

    etmb_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_item,
        .q_valid(fq_valid), .q_stall(fq_stall), .q_item(fq_item)
    );

    etmb_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_item(fq_item),
        .rd_valid(qb_valid), .rd_take(qb_take), .rd_item(qb_item)
    );

    etmb_back u_back (
        .clk, .rst_n,
        .q_valid(qb_valid), .q_take(qb_take), .q_item(qb_item),
        .out_valid, .out_stall, .out_item
    );
endmodule

// ----- rtl/etmb_cordic.sv -----
module etmb_cordic
(
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [15:0]                  ang,
    output logic signed [etmb_pkg::QW-1:0]      cos_o,
    output logic signed [etmb_pkg::QW-1:0]      sin_o
);
    localparam int N = etmb_pkg::TRIG_ITERATIONS;

    logic signed [etmb_pkg::QW-1:0] x_reg [N+1];
    logic signed [etmb_pkg::QW-1:0] y_reg [N+1];
    logic signed [etmb_pkg::QW-1:0] z_reg [N+1];
    logic                           f_reg [N+1];

    logic signed [etmb_pkg::QW-1:0] z0;
    logic                           f0;

    always_comb
    begin
        z0 = {{(etmb_pkg::QW-28){ang[15]}}, ang, 12'd0};
        f0 = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (z0 > etmb_pkg::Q24_HALF_PI)
            begin
                z0 = z0 - etmb_pkg::Q24_PI;
                f0 = ~f0;
            end
            else if (z0 < -etmb_pkg::Q24_HALF_PI)
            begin
                z0 = z0 + etmb_pkg::Q24_PI;
                f0 = ~f0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= etmb_pkg::Q24_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
            f_reg[0] <= f0;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_st
        localparam int SH = (i < 62) ? i : 62;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][etmb_pkg::QW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> SH);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> SH);
                    z_reg[i+1] <= z_reg[i] - etmb_pkg::atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> SH);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> SH);
                    z_reg[i+1] <= z_reg[i] + etmb_pkg::atan_step(i);
                end
            end
        end
    end

    assign cos_o = f_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_o = f_reg[N] ? -y_reg[N] : y_reg[N];
endmodule

// ----- rtl/etmb_front.sv -----
module etmb_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  etmb_pkg::in_item_t      in_item,
    output logic                    q_valid,
    input  logic                    q_stall,
    output etmb_pkg::trig_item_t    q_item
);
    localparam int N = etmb_pkg::TRIG_ITERATIONS;
    localparam int D = N + 1;

    logic                 v_reg [D];
    etmb_pkg::in_item_t   p_reg [D];
    logic                 adv;

    // pipeline advances when the output stage is free or leaving
    assign adv      = !(v_reg[D-1] && q_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++) v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < D; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= in_item;
            for (int i = 1; i < D; i++) p_reg[i] <= p_reg[i-1];
        end
    end

    logic signed [etmb_pkg::QW-1:0] cx, sx, cy, sy, cz, sz;

    etmb_cordic u_cx (.clk, .adv, .ang(in_item.pitch_angle), .cos_o(cx), .sin_o(sx));
    etmb_cordic u_cy (.clk, .adv, .ang(in_item.yaw_angle),   .cos_o(cy), .sin_o(sy));
    etmb_cordic u_cz (.clk, .adv, .ang(in_item.roll_angle),  .cos_o(cz), .sin_o(sz));

    assign q_valid = v_reg[D-1];
    always_comb
    begin
        q_item.cx = cx;
        q_item.sx = sx;
        q_item.cy = cy;
        q_item.sy = sy;
        q_item.cz = cz;
        q_item.sz = sz;
        q_item.pos_x   = p_reg[D-1].pos_x;
        q_item.pos_y   = p_reg[D-1].pos_y;
        q_item.pos_z   = p_reg[D-1].pos_z;
        q_item.scale_x = p_reg[D-1].scale_x;
        q_item.scale_y = p_reg[D-1].scale_y;
        q_item.scale_z = p_reg[D-1].scale_z;
    end
endmodule

// ----- rtl/etmb_queue.sv -----
module etmb_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_valid,
    output logic                    wr_stall,
    input  etmb_pkg::trig_item_t    wr_item,
    output logic                    rd_valid,
    input  logic                    rd_take,
    output etmb_pkg::trig_item_t    rd_item
);
    etmb_pkg::trig_item_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_take && rd_valid;
    assign rd_item = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wr_item;
    end
endmodule

// ----- rtl/etmb_back.sv -----
module etmb_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_take,
    input  etmb_pkg::trig_item_t    q_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output etmb_pkg::out_item_t     out_item
);
    // stage A: shared products; stage B: rotation entries; then one row per cycle while the output is not stalled
    logic                        a_v_reg, b_v_reg;
    etmb_pkg::trig_item_t        a_reg;
    logic signed [31:0]          sxsy_reg, cxsy_reg;
    logic signed [31:0]          r_reg [9];
    logic signed [31:0]          rn    [9];
    logic signed [31:0]          b_pos_reg [3];
    logic signed [31:0]          b_sc_reg  [3];
    logic [1:0]                  row_reg;
    logic                        row_adv, b_free, a_free;
    logic signed [31:0]          e0, e1, e2, pcol;

    assign row_adv = b_v_reg && !(out_valid && out_stall);
    assign b_free  = !b_v_reg || (row_adv && row_reg == 2'd3);
    assign a_free  = !a_v_reg || b_free;
    assign q_take  = a_free;

    function automatic logic signed [31:0] m(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        return etmb_pkg::rnd24(64'(a) * 64'(b));
    endfunction

    always_comb
    begin
        rn[0] = m(a_reg.cy, a_reg.cz);
        rn[1] = -m(a_reg.cy, a_reg.sz);
        rn[2] = a_reg.sy;
        rn[3] = m(sxsy_reg, a_reg.cz) + m(a_reg.cx, a_reg.sz);
        rn[4] = m(a_reg.cx, a_reg.cz) - m(sxsy_reg, a_reg.sz);
        rn[5] = -m(a_reg.sx, a_reg.cy);
        rn[6] = m(a_reg.sx, a_reg.sz) - m(cxsy_reg, a_reg.cz);
        rn[7] = m(cxsy_reg, a_reg.sz) + m(a_reg.sx, a_reg.cz);
        rn[8] = m(a_reg.cx, a_reg.cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            row_reg <= 2'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (a_free) a_v_reg <= q_valid;
            if (b_free)
            begin
                b_v_reg <= a_v_reg;
                row_reg <= 2'd0;
            end
            else if (row_adv) row_reg <= row_reg + 2'd1;
            if (!(out_valid && out_stall)) out_valid <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_reg    <= q_item;
            sxsy_reg <= m(q_item.sx, q_item.sy);
            cxsy_reg <= m(q_item.cx, q_item.sy);
        end
        if (b_free)
        begin
            for (int i = 0; i < 9; i++) r_reg[i] <= rn[i];
            b_pos_reg[0] <= a_reg.pos_x;
            b_pos_reg[1] <= a_reg.pos_y;
            b_pos_reg[2] <= a_reg.pos_z;
            b_sc_reg[0]  <= a_reg.scale_x;
            b_sc_reg[1]  <= a_reg.scale_y;
            b_sc_reg[2]  <= a_reg.scale_z;
        end
    end

    always_comb
    begin
        e0 = 32'sd0; e1 = 32'sd0; e2 = 32'sd0; pcol = etmb_pkg::Q16_ONE;
        case (row_reg)
            2'd0:
            begin
                e0 = etmb_pkg::sat_rnd24(64'(r_reg[0]) * 64'(b_sc_reg[0]));
                e1 = etmb_pkg::sat_rnd24(64'(r_reg[1]) * 64'(b_sc_reg[1]));
                e2 = etmb_pkg::sat_rnd24(64'(r_reg[2]) * 64'(b_sc_reg[2]));
                pcol = b_pos_reg[0];
            end
            2'd1:
            begin
                e0 = etmb_pkg::sat_rnd24(64'(r_reg[3]) * 64'(b_sc_reg[0]));
                e1 = etmb_pkg::sat_rnd24(64'(r_reg[4]) * 64'(b_sc_reg[1]));
                e2 = etmb_pkg::sat_rnd24(64'(r_reg[5]) * 64'(b_sc_reg[2]));
                pcol = b_pos_reg[1];
            end
            2'd2:
            begin
                e0 = etmb_pkg::sat_rnd24(64'(r_reg[6]) * 64'(b_sc_reg[0]));
                e1 = etmb_pkg::sat_rnd24(64'(r_reg[7]) * 64'(b_sc_reg[1]));
                e2 = etmb_pkg::sat_rnd24(64'(r_reg[8]) * 64'(b_sc_reg[2]));
                pcol = b_pos_reg[2];
            end
            default:
            begin
                e0 = 32'sd0; e1 = 32'sd0; e2 = 32'sd0; pcol = etmb_pkg::Q16_ONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (!(out_valid && out_stall))
        begin
            out_item.row_index <= row_reg;
            out_item.col0      <= e0;
            out_item.col1      <= e1;
            out_item.col2      <= e2;
            out_item.col3      <= pcol;
            out_item.last_row  <= (row_reg == 2'd3);
        end
    end
endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    etmb_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    etmb_pkg::out_item_t out_item;

    euler_trs_matrix_builder dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    localparam int N_RANDOM = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        etmb_pkg::in_item_t item;
        logic               fixed_row3;
    } stim_row_t;

    etmb_pkg::out_item_t expected_rows[$];
    int error_count;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round24(longint v);
        return (v + 64'sd8388608) >>> 24;
    endfunction

    task automatic add_expected(input etmb_pkg::out_item_t r);
        expected_rows.insert(expected_rows.size(), r);
    endtask

    task automatic sin_cos(input logic signed [15:0] ang, output longint c,
                           output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint a;
        bit flip;
        int sh;
        z = longint'(ang) * 4096;
        x = 10188014;
        y = 0;
        flip = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (z > 26353589)
            begin
                z -= 52707179;
                flip = ~flip;
            end
            else if (z < -26353589)
            begin
                z += 52707179;
                flip = ~flip;
            end
        end
        for (int i = 0; i < etmb_pkg::TRIG_ITERATIONS; i++)
        begin
            sh = (i < 62) ? i : 62;
            dx = asr64(y, sh);
            dy = asr64(x, sh);
            case (i)
                0: a = 13176795;
                1: a = 7778716;
                2: a = 4110060;
                3: a = 2086331;
                4: a = 1047214;
                5: a = 524117;
                6: a = 262123;
                7: a = 131069;
                default: a = (i <= 24) ? (64'sd1 <<< (24 - i)) : 0;
            endcase
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= a;
            end
            else
            begin
                x += dx;
                y -= dy;
                z += a;
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic logic signed [31:0] scaled_elem(longint r, longint sc);
        longint t;
        t = round24(r * sc);
        if (t > 64'sd2147483647)
            return 32'sh7fffffff;
        if (t < -64'sd2147483648)
            return 32'sh80000000;
        return t[31:0];
    endfunction

    task automatic predict_matrix(input etmb_pkg::in_item_t it);
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        longint r[3][3];
        longint sc[3];
        logic signed [31:0] pos[3];
        etmb_pkg::out_item_t row;
        sin_cos(it.pitch_angle, cx, sx);
        sin_cos(it.yaw_angle, cy, sy);
        sin_cos(it.roll_angle, cz, sz);
        sxsy = round24(sx * sy);
        cxsy = round24(cx * sy);
        r[0][0] = round24(cy * cz);
        r[0][1] = -round24(cy * sz);
        r[0][2] = sy;
        r[1][0] = round24(sxsy * cz) + round24(cx * sz);
        r[1][1] = round24(cx * cz) - round24(sxsy * sz);
        r[1][2] = -round24(sx * cy);
        r[2][0] = round24(sx * sz) - round24(cxsy * cz);
        r[2][1] = round24(cxsy * sz) + round24(sx * cz);
        r[2][2] = round24(cx * cy);
        sc[0] = it.scale_x;
        sc[1] = it.scale_y;
        sc[2] = it.scale_z;
        pos[0] = it.pos_x;
        pos[1] = it.pos_y;
        pos[2] = it.pos_z;
        for (int k = 0; k < 3; k++)
        begin
            row.row_index = k[1:0];
            row.col0 = scaled_elem(r[k][0], sc[0]);
            row.col1 = scaled_elem(r[k][1], sc[1]);
            row.col2 = scaled_elem(r[k][2], sc[2]);
            row.col3 = pos[k];
            row.last_row = 1'b0;
            add_expected(row);
        end
        row.row_index = 2'd3;
        row.col0 = '0;
        row.col1 = '0;
        row.col2 = '0;
        row.col3 = etmb_pkg::Q16_ONE;
        row.last_row = 1'b1;
        add_expected(row);
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // receiver side
    initial
    begin
        int wait_cycles;
        etmb_pkg::out_item_t want;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 1) == 0)
                wait_cycles = 0;
            out_stall = (wait_cycles != 0);
            repeat (wait_cycles)
                @(negedge clk);
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (expected_rows.size() == 0)
            begin
                report_mismatch("row with no item pending", out_item.row_index, 0);
            end
            else
            begin
                want = expected_rows.pop_front();
                if (out_item.row_index !== want.row_index)
                    report_mismatch("row_index", out_item.row_index, want.row_index);
                if (out_item.col0 !== want.col0)
                    report_mismatch("col0", out_item.col0, want.col0);
                if (out_item.col1 !== want.col1)
                    report_mismatch("col1", out_item.col1, want.col1);
                if (out_item.col2 !== want.col2)
                    report_mismatch("col2", out_item.col2, want.col2);
                if (out_item.col3 !== want.col3)
                    report_mismatch("col3", out_item.col3, want.col3);
                if (out_item.last_row !== want.last_row)
                    report_mismatch("last_row", out_item.last_row, want.last_row);
            end
        end
    end

    task automatic send_item(input etmb_pkg::in_item_t it, input bit idle_gaps);
        int wait_cycles;
        wait_cycles = idle_gaps ? $urandom_range(0, 16) : 0;
        if (idle_gaps && $urandom_range(0, 2) == 0)
            wait_cycles = 0;
        if (wait_cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (wait_cycles)
                @(negedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_matrix(it);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return $signed($urandom_range(0, 262144)) - 32'sd131072;
            default: return $signed($urandom_range(0, 8388608)) - 32'sd4194304;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            default: return $signed(16'($urandom_range(0, 12868))) - 16'sd6434;
        endcase
    endfunction

    stim_row_t directed_rows[$];

    function automatic etmb_pkg::in_item_t make_item(logic signed [31:0] p,
        logic signed [15:0] a0, logic signed [15:0] a1, logic signed [15:0] a2,
        logic signed [31:0] s);
        etmb_pkg::in_item_t it;
        it.pos_x = p;
        it.pos_y = -p;
        it.pos_z = ~p;
        it.pitch_angle = a0;
        it.yaw_angle = a1;
        it.roll_angle = a2;
        it.scale_x = s;
        it.scale_y = s;
        it.scale_z = s;
        return it;
    endfunction

    initial
    begin
        etmb_pkg::in_item_t it;
        stim_row_t row;
        error_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity, extremes of angles and scales, reduction near +-pi, alternating bit patterns, unit values
        row.fixed_row3 = 1'b1;
        row.item = make_item(32'sd0, 16'sd0, 16'sd0, 16'sd0, etmb_pkg::Q16_ONE);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'sd65536, 16'sd6434, -16'sd6434, 16'sd12868,
                             etmb_pkg::Q16_ONE);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(-32'sd1, 16'sd12869, -16'sd12869, 16'sd6435, -32'sd65536);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'sd123456, 16'sd3217, 16'sd3217, 16'sd3217, 32'sd0);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'sh55555555, 16'sh5555, 16'shaaaa, 16'sh5555, 32'shaaaaaaaa);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'shaaaaaaaa, 16'shaaaa, 16'sh5555, 16'shaaaa, 32'sh55555555);
        directed_rows.insert(directed_rows.size(), row);
        row.item = make_item(32'sd1, -16'sd1, 16'sd1, -16'sd1, 32'sd1);
        directed_rows.insert(directed_rows.size(), row);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item, 1'b1);
            if (directed_rows[i].fixed_row3)
            begin
                etmb_pkg::out_item_t tail;
                tail = expected_rows[expected_rows.size() - 1];
                if (tail.row_index !== 2'd3 || tail.col3 !== etmb_pkg::Q16_ONE
                    || !tail.last_row)
                    report_mismatch("bottom row", tail.col3, etmb_pkg::Q16_ONE);
            end
        end

        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            it.pos_x = rand_q16();
            it.pos_y = rand_q16();
            it.pos_z = rand_q16();
            it.pitch_angle = rand_angle();
            it.yaw_angle = rand_angle();
            it.roll_angle = rand_angle();
            it.scale_x = rand_q16();
            it.scale_y = rand_q16();
            it.scale_z = rand_q16();
            send_item(it, !(n >= 100 && n < 150));
            if (n == 200)
            begin
                in_valid <= 1'b0;
                while (expected_rows.size() != 0)
                    @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        while (expected_rows.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/etmb_pkg.sv
rtl/etmb_cordic.sv
rtl/etmb_front.sv
rtl/etmb_queue.sv
rtl/etmb_back.sv
rtl/euler_trs_matrix_builder.sv
dv/tb_top.sv
